FILE: hdl/tmis_pkg.sv
`default_nettype none

package tmis_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 48;
  localparam int unsigned ExtW = WideW + 1;
  localparam int unsigned MagW = WideW - 1;
  localparam int unsigned SumW = WideW + 3;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned RndW = MagW + DataW + 1;
  localparam int unsigned DigW = 13;
  localparam int unsigned DivSteps = 4;
  localparam int unsigned DivW = DigW * DivSteps;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned RemW = 3;
  localparam int unsigned DivXW = RemW + DigW;
  localparam int unsigned Recip6Shift = 18;

  localparam logic signed [WideW-1:0] WideMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};
  localparam logic [DivXW-1:0] Recip6 = 16'd43691;
  localparam logic [DivXW-1:0] AvgDiv = 16'd6;
  localparam logic [DivW-1:0] AvgBias = 52'd3;

  localparam logic [DataW-1:0] InvCapReset = 32'd4294967;
  localparam logic [DataW-1:0] LossReset = 32'd65536;
  localparam logic [DataW-1:0] StepReset = 32'd6554;
  localparam logic signed [DataW-1:0] StartReset = 32'sd1638400;

  typedef enum logic [2:0] {
    REG_INV_CAPACITY  = 3'd0,
    REG_LOSS_COEFF    = 3'd1,
    REG_STEP_TIME     = 3'd2,
    REG_METHOD_SELECT = 3'd3,
    REG_START_TEMP    = 3'd4
  } reg_idx_e;

  typedef enum logic {
    METHOD_EULER = 1'b0,
    METHOD_RK4   = 1'b1
  } method_e;

  typedef struct packed {
    logic [DataW-1:0]        inv_capacity;
    logic [DataW-1:0]        loss_coeff;
    logic [DataW-1:0]        step_time;
    method_e                 method_select;
    logic signed [DataW-1:0] start_temp;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_MLO,
    OP_MHI,
    OP_MRND,
    OP_ACC,
    OP_POINT,
    OP_DINIT,
    OP_DSTEP,
    OP_FINAL
  } op_e;

  typedef enum logic [1:0] {
    SRC_DIFF,
    SRC_NET,
    SRC_K,
    SRC_AVG
  } src_e;

  typedef enum logic [1:0] {
    COEF_H,
    COEF_INVC,
    COEF_DT
  } coef_e;

  typedef enum logic [1:0] {
    SH_16,
    SH_17,
    SH_32
  } shift_e;

  typedef struct packed {
    op_e    op;
    src_e   src;
    coef_e  coef;
    shift_e shift;
    logic   dbl;
  } cmd_t;

  function automatic logic signed [WideW-1:0] sat_wide(input logic signed [ExtW-1:0] v);
    logic signed [ExtW-1:0] lim;
    lim = ExtW'(WideMax);
    if (v > lim) begin
      return WideMax;
    end else if (v < -lim) begin
      return -WideMax;
    end
    return v[WideW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [ExtW-1:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tmis_in_if.sv
`default_nettype none

interface tmis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 restore;
  logic signed [tmis_pkg::DataW-1:0]    heat_power;
  logic signed [tmis_pkg::DataW-1:0]    ambient_temp;

  modport source (output valid, output restore, output heat_power, output ambient_temp,
                  input ready);
  modport sink (input valid, input restore, input heat_power, input ambient_temp,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/tmis_out_if.sv
`default_nettype none

interface tmis_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tmis_pkg::DataW-1:0] mass_temp;

  modport source (output valid, output mass_temp, input ready);
  modport sink (input valid, input mass_temp, output ready);
endinterface

`default_nettype wire

FILE: hdl/tmis_ctrl.sv
`default_nettype none

module tmis_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_restore_i,
  input  logic           rk4_i,
  input  logic           out_free_i,
  output logic           in_ready_o,
  output logic           push_o,
  output tmis_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MLO,
    S_MHI,
    S_MRND,
    S_ACC,
    S_POINT,
    S_DINIT,
    S_DIV,
    S_FINAL,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_LOSS,
    PH_RATE,
    PH_STEP,
    PH_AVG
  } phase_e;

  localparam logic [1:0] LastStage = 2'd3;
  localparam logic [1:0] LastPoint = 2'd2;
  localparam logic [tmis_pkg::DivCntW-1:0] LastDigit =
    tmis_pkg::DivCntW'(tmis_pkg::DivSteps - 1);

  state_e                        state_q;
  phase_e                        phase_q;
  logic [1:0]                    stage_q;
  logic [tmis_pkg::DivCntW-1:0]  dcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_LOSS;
      stage_q <= '0;
      dcnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            phase_q <= PH_LOSS;
            stage_q <= '0;
            state_q <= in_restore_i ? S_DONE : S_PREP;
          end
        end
        S_PREP: state_q <= S_MLO;
        S_MLO:  state_q <= S_MHI;
        S_MHI:  state_q <= S_MRND;
        S_MRND: begin
          unique case (phase_q)
            PH_LOSS: begin
              phase_q <= PH_RATE;
              state_q <= S_PREP;
            end
            PH_RATE: begin
              if (rk4_i) begin
                state_q <= S_ACC;
              end else begin
                phase_q <= PH_STEP;
                state_q <= S_PREP;
              end
            end
            PH_STEP: state_q <= rk4_i ? S_POINT : S_FINAL;
            PH_AVG:  state_q <= S_FINAL;
            default: state_q <= S_FINAL;
          endcase
        end
        S_ACC: begin
          if (stage_q == LastStage) begin
            state_q <= S_DINIT;
          end else begin
            phase_q <= PH_STEP;
            state_q <= S_PREP;
          end
        end
        S_POINT: begin
          stage_q <= stage_q + 2'd1;
          phase_q <= PH_LOSS;
          state_q <= S_PREP;
        end
        S_DINIT: begin
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_q == LastDigit) begin
            phase_q <= PH_AVG;
            state_q <= S_PREP;
          end else begin
            dcnt_q <= dcnt_q + tmis_pkg::DivCntW'(1);
          end
        end
        S_FINAL: state_q <= S_DONE;
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    push_o     = (state_q == S_DONE) && out_free_i;

    cmd_o = '{op: tmis_pkg::OP_NONE, src: tmis_pkg::SRC_DIFF, coef: tmis_pkg::COEF_H,
              shift: tmis_pkg::SH_16, dbl: 1'b0};

    unique case (phase_q)
      PH_LOSS: begin
        cmd_o.src   = tmis_pkg::SRC_DIFF;
        cmd_o.coef  = tmis_pkg::COEF_H;
        cmd_o.shift = tmis_pkg::SH_16;
      end
      PH_RATE: begin
        cmd_o.src   = tmis_pkg::SRC_NET;
        cmd_o.coef  = tmis_pkg::COEF_INVC;
        cmd_o.shift = tmis_pkg::SH_32;
      end
      PH_STEP: begin
        cmd_o.src   = tmis_pkg::SRC_K;
        cmd_o.coef  = tmis_pkg::COEF_DT;
        cmd_o.shift = (rk4_i && (stage_q != LastPoint)) ? tmis_pkg::SH_17 : tmis_pkg::SH_16;
      end
      default: begin
        cmd_o.src   = tmis_pkg::SRC_AVG;
        cmd_o.coef  = tmis_pkg::COEF_DT;
        cmd_o.shift = tmis_pkg::SH_16;
      end
    endcase

    cmd_o.dbl = (stage_q != 2'd0) && (stage_q != LastStage);

    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? tmis_pkg::OP_LOAD : tmis_pkg::OP_NONE;
      S_PREP:  cmd_o.op = tmis_pkg::OP_PREP;
      S_MLO:   cmd_o.op = tmis_pkg::OP_MLO;
      S_MHI:   cmd_o.op = tmis_pkg::OP_MHI;
      S_MRND:  cmd_o.op = tmis_pkg::OP_MRND;
      S_ACC:   cmd_o.op = tmis_pkg::OP_ACC;
      S_POINT: cmd_o.op = tmis_pkg::OP_POINT;
      S_DINIT: cmd_o.op = tmis_pkg::OP_DINIT;
      S_DIV:   cmd_o.op = tmis_pkg::OP_DSTEP;
      S_FINAL: cmd_o.op = tmis_pkg::OP_FINAL;
      default: cmd_o.op = tmis_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tmis_datapath.sv
`default_nettype none

module tmis_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmis_pkg::cmd_t                    cmd_i,
  input  tmis_pkg::cfg_t                    cfg_i,
  input  logic                              restore_i,
  input  logic signed [tmis_pkg::DataW-1:0] heat_power_i,
  input  logic signed [tmis_pkg::DataW-1:0] ambient_temp_i,
  output logic signed [tmis_pkg::DataW-1:0] temp_o
);

  localparam int unsigned DataW = tmis_pkg::DataW;
  localparam int unsigned WideW = tmis_pkg::WideW;
  localparam int unsigned ExtW  = tmis_pkg::ExtW;
  localparam int unsigned MagW  = tmis_pkg::MagW;
  localparam int unsigned SumW  = tmis_pkg::SumW;
  localparam int unsigned ProdW = tmis_pkg::ProdW;
  localparam int unsigned RndW  = tmis_pkg::RndW;
  localparam int unsigned DigW  = tmis_pkg::DigW;
  localparam int unsigned DivW  = tmis_pkg::DivW;
  localparam int unsigned DivXW = tmis_pkg::DivXW;
  localparam int unsigned RemW  = tmis_pkg::RemW;

  logic signed [DataW-1:0] t_q;
  logic signed [DataW-1:0] pw_q;
  logic signed [DataW-1:0] amb_q;
  logic signed [WideW-1:0] pt_q;
  logic                    mneg_q;
  logic [MagW-1:0]         mag_q;
  logic [ProdW-1:0]        plo_q;
  logic [MagW-1:0]         phi_q;
  logic signed [WideW-1:0] mr_q;
  logic signed [SumW-1:0]  sum_q;
  logic [DivW-1:0]         dv_q;
  logic [RemW-1:0]         rem_q;
  logic                    dneg_q;

  logic [DataW-1:0]        coef;
  logic signed [ExtW-1:0]  diff_sub;
  logic signed [ExtW-1:0]  net_sub;
  logic signed [WideW-1:0] opnd;
  logic signed [WideW-1:0] opnd_abs;
  logic                    prep_neg;
  logic [MagW-1:0]         prep_mag;
  logic [DataW-1:0]        mul_a;
  logic [ProdW-1:0]        prod;
  logic [RndW-1:0]         half;
  logic [RndW-1:0]         full;
  logic [RndW-1:0]         shr;
  logic [MagW-1:0]         rnd_mag;
  logic signed [WideW-1:0] rnd_pos;
  logic signed [WideW-1:0] rnd;
  logic signed [ExtW-1:0]  t_add;
  logic signed [SumW-1:0]  acc_add;
  logic signed [SumW-1:0]  sum_abs;
  logic [DivXW-1:0]        dx;
  logic [2*DivXW-1:0]      qprod;
  logic [DigW-1:0]         qdig;
  logic [DivXW-1:0]        rem_full;

  always_comb begin
    case (cmd_i.coef)
      tmis_pkg::COEF_H:    coef = cfg_i.loss_coeff;
      tmis_pkg::COEF_INVC: coef = cfg_i.inv_capacity;
      default:             coef = cfg_i.step_time;
    endcase

    diff_sub = ExtW'(pt_q) - ExtW'(amb_q);
    net_sub  = ExtW'(pw_q) - ExtW'(mr_q);
    case (cmd_i.src)
      tmis_pkg::SRC_DIFF: opnd = tmis_pkg::sat_wide(diff_sub);
      tmis_pkg::SRC_NET:  opnd = tmis_pkg::sat_wide(net_sub);
      default:            opnd = mr_q;
    endcase
    opnd_abs = opnd[WideW-1] ? -opnd : opnd;
    if (cmd_i.src == tmis_pkg::SRC_AVG) begin
      prep_neg = dneg_q;
      prep_mag = dv_q[MagW-1:0];
    end else begin
      prep_neg = opnd[WideW-1];
      prep_mag = opnd_abs[MagW-1:0];
    end

    mul_a = (cmd_i.op == tmis_pkg::OP_MHI) ? DataW'(mag_q[MagW-1:DataW]) : mag_q[DataW-1:0];
    prod  = ProdW'(mul_a) * ProdW'(coef);

    full = {1'b0, phi_q, {DataW{1'b0}}} + RndW'(plo_q);
    case (cmd_i.shift)
      tmis_pkg::SH_16: begin
        half = RndW'(1) << 15;
        shr  = (full + half) >> 16;
      end
      tmis_pkg::SH_17: begin
        half = RndW'(1) << 16;
        shr  = (full + half) >> 17;
      end
      default: begin
        half = RndW'(1) << 31;
        shr  = (full + half) >> 32;
      end
    endcase
    rnd_mag = (shr > RndW'(tmis_pkg::MagMax)) ? tmis_pkg::MagMax : shr[MagW-1:0];
    rnd_pos = signed'({1'b0, rnd_mag});
    rnd     = mneg_q ? -rnd_pos : rnd_pos;

    t_add   = ExtW'(t_q) + ExtW'(mr_q);
    acc_add = cmd_i.dbl ? (SumW'(mr_q) <<< 1) : SumW'(mr_q);
    sum_abs = sum_q[SumW-1] ? -sum_q : sum_q;

    dx       = {rem_q, dv_q[DivW-1 -: DigW]};
    qprod    = {{DivXW{1'b0}}, dx} * {{DivXW{1'b0}}, tmis_pkg::Recip6};
    qdig     = qprod[tmis_pkg::Recip6Shift +: DigW];
    rem_full = dx - (DivXW'(qdig) * tmis_pkg::AvgDiv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= tmis_pkg::StartReset;
    end else begin
      case (cmd_i.op)
        tmis_pkg::OP_LOAD: begin
          if (restore_i) begin
            t_q <= cfg_i.start_temp;
          end
        end
        tmis_pkg::OP_FINAL: t_q <= tmis_pkg::sat32(t_add);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tmis_pkg::OP_LOAD: begin
        pw_q  <= heat_power_i;
        amb_q <= ambient_temp_i;
        pt_q  <= WideW'(t_q);
        sum_q <= '0;
      end
      tmis_pkg::OP_PREP: begin
        mneg_q <= prep_neg;
        mag_q  <= prep_mag;
      end
      tmis_pkg::OP_MLO:   plo_q <= prod;
      tmis_pkg::OP_MHI:   phi_q <= prod[MagW-1:0];
      tmis_pkg::OP_MRND:  mr_q <= rnd;
      tmis_pkg::OP_ACC:   sum_q <= sum_q + acc_add;
      tmis_pkg::OP_POINT: pt_q <= tmis_pkg::sat_wide(t_add);
      tmis_pkg::OP_DINIT: begin
        dv_q   <= DivW'(sum_abs[SumW-2:0]) + tmis_pkg::AvgBias;
        dneg_q <= sum_q[SumW-1];
        rem_q  <= '0;
      end
      tmis_pkg::OP_DSTEP: begin
        dv_q  <= {dv_q[DivW-DigW-1:0], qdig};
        rem_q <= rem_full[RemW-1:0];
      end
      default: ;
    endcase
  end

  assign temp_o = t_q;

endmodule

`default_nettype wire

FILE: hdl/thermal_mass_integration_step_unit.sv
// Lumped thermal mass integrator: one time step per input word.
// The input channel carries restore, heat_power and ambient_temp (Q16.16); the
// output channel returns mass_temp (Q16.16, saturated), one word per input word.
// The user must write registers through cfg_we_i, cfg_idx_i and cfg_wdata_i only
// while the block is idle, which the block does not enforce: 0 inv_capacity,
// 1 loss_coeff, 2 step_time, 3 method_select, 4 start_temp; others are ignored.
// Every step runs on one shared 32x32 multiplier; each rounded product passes
// through prepare, low-half, high-half and round steps. Forward Euler takes three
// products; RK4 takes twelve products plus a divide by six. A restore word skips
// the arithmetic and returns start_temp. A new word is taken only once the
// previous result has been handed to the output register.
// Reset loads the register defaults and sets the temperature to 25.0 degC.
// The result sits in an output register, so the receiver may stall; the next
// word is accepted and worked on meanwhile and waits only to be handed over.
`default_nettype none

module thermal_mass_integration_step_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tmis_in_if.sink                     in_i,
  tmis_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [tmis_pkg::DataW-1:0]  cfg_wdata_i
);

  tmis_pkg::cfg_t                    cfg_q;
  tmis_pkg::cmd_t                    cmd;
  logic                              in_ready;
  logic                              push;
  logic                              out_free;
  logic                              out_valid_q;
  logic signed [tmis_pkg::DataW-1:0] out_data_q;
  logic signed [tmis_pkg::DataW-1:0] temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{inv_capacity: tmis_pkg::InvCapReset, loss_coeff: tmis_pkg::LossReset,
                 step_time: tmis_pkg::StepReset, method_select: tmis_pkg::METHOD_EULER,
                 start_temp: tmis_pkg::StartReset};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmis_pkg::REG_INV_CAPACITY:  cfg_q.inv_capacity <= cfg_wdata_i;
        tmis_pkg::REG_LOSS_COEFF:    cfg_q.loss_coeff <= cfg_wdata_i;
        tmis_pkg::REG_STEP_TIME:     cfg_q.step_time <= cfg_wdata_i;
        tmis_pkg::REG_METHOD_SELECT: cfg_q.method_select <= tmis_pkg::method_e'(cfg_wdata_i[0]);
        tmis_pkg::REG_START_TEMP:    cfg_q.start_temp <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  tmis_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restore_i (in_i.restore),
    .rk4_i        (cfg_q.method_select == tmis_pkg::METHOD_RK4),
    .out_free_i   (out_free),
    .in_ready_o   (in_ready),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  tmis_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg_q),
    .restore_i      (in_i.restore),
    .heat_power_i   (in_i.heat_power),
    .ambient_temp_i (in_i.ambient_temp),
    .temp_o         (temp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_data_q <= temp;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.mass_temp = out_data_q;

`ifndef NO_ASSERTIONS
  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || out_o.ready))
    else $error("Result word written over an unaccepted output word.");

  a_restore_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.restore) |=> (temp == $past(cfg_q.start_temp)))
    else $error("Restore word did not load the start temperature.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Input accepted again before the current word was finished.");
`endif

endmodule

`default_nettype wire

FILE: verif/thermal_mass_integration_step_unit_tb.sv
`timescale 1ns / 100ps

module thermal_mass_integration_step_unit_tb;

  localparam longint WideLimit = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic [2:0] IdxTop = 3'd7;
  localparam logic signed [31:0] TempMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TempMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_wdata;

  tmis_in_if in_bus ();
  tmis_out_if out_bus ();

  thermal_mass_integration_step_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  logic [31:0] model_inv_cap;
  logic [31:0] model_loss;
  logic [31:0] model_dt;
  tmis_pkg::method_e model_method;
  logic signed [31:0] model_start;
  logic signed [31:0] model_temp;

  logic signed [31:0] expected_temps[$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  logic hold_req;
  int unsigned hold_len;
  int unsigned holdoff_count;
  int unsigned euler_count;
  int unsigned rk4_count;
  int unsigned restore_count;
  int unsigned write_count;
  int unsigned limit_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clamp_wide(longint v);
    if (v > WideLimit) return WideLimit;
    if (v < -WideLimit) return -WideLimit;
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_temp(longint v);
    if (v > 64'sd2147483647) return TempMax;
    if (v < -64'sd2147483648) return TempMin;
    return v[31:0];
  endfunction

  // Rounds a * b / 2^s half away from zero, clamped to the wide range.
  function automatic longint scaled_round(longint a, logic [31:0] b, int unsigned s);
    logic [63:0] mag;
    logic [95:0] prod;
    longint m;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    prod = {32'd0, mag} * {64'd0, b};
    prod = prod + (96'd1 << (s - 1));
    prod = prod >> s;
    m = (prod > 96'(WideLimit)) ? WideLimit : longint'(prod[63:0]);
    return (a < 0) ? -m : m;
  endfunction

  function automatic longint heat_rate(longint t, longint p, longint amb);
    longint diff;
    longint loss;
    longint net;
    diff = clamp_wide(t - amb);
    loss = scaled_round(diff, model_loss, 16);
    net = clamp_wide(p - loss);
    return scaled_round(net, model_inv_cap, 32);
  endfunction

  function automatic longint sixth_round(longint v);
    if (v >= 0) return (v + 3) / 6;
    return -((-v + 3) / 6);
  endfunction

  function automatic logic signed [31:0] next_temp(logic restore, logic signed [31:0] power,
                                                   logic signed [31:0] ambient);
    longint t;
    longint p;
    longint amb;
    longint k1;
    longint k2;
    longint k3;
    longint k4;
    longint avg;
    t = longint'(model_temp);
    p = longint'(power);
    amb = longint'(ambient);
    if (restore) return model_start;
    if (model_method == tmis_pkg::METHOD_EULER) begin
      k1 = heat_rate(t, p, amb);
      return clamp_temp(t + scaled_round(k1, model_dt, 16));
    end
    k1 = heat_rate(t, p, amb);
    k2 = heat_rate(clamp_wide(t + scaled_round(k1, model_dt, 17)), p, amb);
    k3 = heat_rate(clamp_wide(t + scaled_round(k2, model_dt, 17)), p, amb);
    k4 = heat_rate(clamp_wide(t + scaled_round(k3, model_dt, 16)), p, amb);
    avg = sixth_round(k1 + 2 * k2 + 2 * k3 + k4);
    return clamp_temp(t + scaled_round(avg, model_dt, 16));
  endfunction

  function automatic logic [31:0] pick_gain(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom();
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_q16(int unsigned mag_max);
    logic signed [31:0] v;
    if ($urandom_range(0, 3) == 0) return $urandom();
    v = $urandom_range(0, mag_max);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (expected_temps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      tmis_pkg::REG_INV_CAPACITY: model_inv_cap = value;
      tmis_pkg::REG_LOSS_COEFF: model_loss = value;
      tmis_pkg::REG_STEP_TIME: model_dt = value;
      tmis_pkg::REG_METHOD_SELECT: model_method = tmis_pkg::method_e'(value[0]);
      tmis_pkg::REG_START_TEMP: model_start = value;
      default: ;
    endcase
    write_count++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_defaults();
    write_reg(tmis_pkg::REG_INV_CAPACITY, tmis_pkg::InvCapReset);
    write_reg(tmis_pkg::REG_LOSS_COEFF, tmis_pkg::LossReset);
    write_reg(tmis_pkg::REG_STEP_TIME, tmis_pkg::StepReset);
    write_reg(tmis_pkg::REG_METHOD_SELECT, 32'(tmis_pkg::METHOD_EULER));
    write_reg(tmis_pkg::REG_START_TEMP, tmis_pkg::StartReset);
  endtask

  task automatic send_word(logic restore, logic signed [31:0] power,
                           logic signed [31:0] ambient);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    in_bus.valid <= 1'b1;
    in_bus.restore <= restore;
    in_bus.heat_power <= power;
    in_bus.ambient_temp <= ambient;
    do @(posedge clk); while (!in_bus.ready);
    if (restore) restore_count++;
    else if (model_method == tmis_pkg::METHOD_RK4) rk4_count++;
    else euler_count++;
    model_temp = next_temp(restore, power, ambient);
    expected_temps.push_back(model_temp);
    burst_left--;
  endtask

  task automatic test_defaults();
    send_word(1'b0, 32'sd0, 32'sd1638400);
    send_word(1'b0, 32'sd6553600, 32'sd1310720);
    send_word(1'b1, $urandom(), $urandom());
    send_word(1'b0, TempMax, TempMin);
    send_word(1'b0, TempMin, TempMax);
  endtask

  task automatic test_saturation();
    write_reg(tmis_pkg::REG_INV_CAPACITY, 32'hFFFF_FFFF);
    write_reg(tmis_pkg::REG_LOSS_COEFF, 32'd1);
    write_reg(tmis_pkg::REG_STEP_TIME, 32'hFFFF_FFFF);
    send_word(1'b0, TempMax, 32'sd0);
    send_word(1'b0, TempMax, 32'sd0);
    send_word(1'b0, TempMin, 32'sd0);
    send_word(1'b0, TempMin, 32'sd0);
  endtask

  task automatic test_rk4_extremes();
    write_reg(tmis_pkg::REG_METHOD_SELECT, 32'(tmis_pkg::METHOD_RK4));
    send_word(1'b0, TempMax, TempMin);
    send_word(1'b0, TempMin, TempMax);
    send_word(1'b0, 32'sd0, 32'sd0);
  endtask

  task automatic test_zero_registers();
    write_reg(tmis_pkg::REG_LOSS_COEFF, 32'hFFFF_FFFF);
    write_reg(tmis_pkg::REG_INV_CAPACITY, 32'd0);
    send_word(1'b0, 32'sd6553600, TempMin);
    write_reg(tmis_pkg::REG_INV_CAPACITY, tmis_pkg::InvCapReset);
    write_reg(tmis_pkg::REG_LOSS_COEFF, 32'd0);
    send_word(1'b0, 32'sd6553600, TempMax);
    write_reg(tmis_pkg::REG_STEP_TIME, 32'd0);
    send_word(1'b0, TempMax, 32'sd0);
  endtask

  task automatic test_start_temp();
    write_defaults();
    write_reg(tmis_pkg::REG_START_TEMP, -32'sd2621440);
    send_word(1'b0, 32'sd655360, 32'sd0);
    send_word(1'b1, 32'sd0, 32'sd0);
    write_reg(tmis_pkg::REG_START_TEMP, TempMax);
    send_word(1'b1, $urandom(), $urandom());
    write_reg(tmis_pkg::REG_START_TEMP, TempMin);
    send_word(1'b1, $urandom(), $urandom());
    send_word(1'b0, TempMax, 32'sd0);
  endtask

  task automatic test_unused_index();
    for (int i = int'(tmis_pkg::REG_START_TEMP) + 1; i <= int'(IdxTop); i++) begin
      write_reg(3'(i), $urandom());
    end
    send_word(1'b0, 32'sd6553600, 32'sd1310720);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(tmis_pkg::REG_INV_CAPACITY, pick_gain(32'd1 << 16, 32'd1 << 26));
      write_reg(tmis_pkg::REG_LOSS_COEFF, pick_gain(32'd1 << 10, 32'd1 << 22));
      write_reg(tmis_pkg::REG_STEP_TIME, pick_gain(32'd1 << 10, 32'd1 << 18));
      write_reg(tmis_pkg::REG_METHOD_SELECT, $urandom_range(0, 1));
      write_reg(tmis_pkg::REG_START_TEMP, pick_q16(32'd200 << 16));
      if ($urandom_range(0, 1) == 1) send_word(1'b1, $urandom(), $urandom());
      repeat (80) begin
        send_word($urandom_range(0, 15) == 0, pick_q16(32'd2000 << 16), pick_q16(32'd200 << 16));
      end
    end
  endtask

  task automatic test_output_holdoff();
    write_defaults();
    settle();
    burst_left = 1000;
    hold_len = 400;
    hold_req = 1'b1;
    repeat (30) begin
      send_word($urandom_range(0, 15) == 0, pick_q16(32'd2000 << 16), pick_q16(32'd200 << 16));
    end
    burst_left = 0;
    settle();
  endtask

  initial begin : receiver
    stall_style_e style;
    int unsigned left;
    int unsigned hold;
    style = STALL_NONE;
    left = 0;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = hold_len;
        holdoff_count++;
      end
      if (hold != 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          style = stall_style_e'($urandom_range(0, 3));
          left = $urandom_range(20, 300);
        end
        left--;
        case (style)
          STALL_NONE: out_bus.ready <= 1'b1;
          STALL_RANDOM: out_bus.ready <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY: out_bus.ready <= ($urandom_range(0, 4) == 0);
          default: out_bus.ready <= ((left % 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_temps
    logic signed [31:0] want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_temps.size() == 0) begin
        $error("mass_temp: no word expected, got %0d", out_bus.mass_temp);
        mismatch_count++;
      end else begin
        want = expected_temps.pop_front();
        if (out_bus.mass_temp !== want) begin
          $error("mass_temp: expected %0d, got %0d", want, out_bus.mass_temp);
          mismatch_count++;
        end
        if (want == TempMax || want == TempMin) limit_count++;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_len = 0;
    holdoff_count = 0;
    euler_count = 0;
    rk4_count = 0;
    restore_count = 0;
    write_count = 0;
    limit_count = 0;
    model_inv_cap = tmis_pkg::InvCapReset;
    model_loss = tmis_pkg::LossReset;
    model_dt = tmis_pkg::StepReset;
    model_method = tmis_pkg::METHOD_EULER;
    model_start = tmis_pkg::StartReset;
    model_temp = tmis_pkg::StartReset;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.restore <= 1'b0;
    in_bus.heat_power <= '0;
    in_bus.ambient_temp <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_saturation();
    test_rk4_extremes();
    test_zero_registers();
    test_start_temp();
    test_unused_index();
    test_random_settings();
    test_output_holdoff();

    settle();
    repeat (80) @(posedge clk);
    $display("Covered %0d Euler steps, %0d RK4 steps and %0d restores across %0d register writes.",
             euler_count, rk4_count, restore_count, write_count);
    $display("%0d results sat at a temperature limit; the output was held off %0d time(s).",
             limit_count, holdoff_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
